@@ hw/rtl/id_handle_table_macros.svh @@
// ----------------------------------------------------------------------------
// id_handle_table_macros.svh
// Assertion macros shared by the handle table RTL.
// ----------------------------------------------------------------------------
`ifndef ID_HANDLE_TABLE_MACROS_SVH
`define ID_HANDLE_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IHT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("id_handle_table: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("id_handle_table: next-cycle check failed");

`endif

@@ hw/rtl/iht_pkg.sv @@
// ----------------------------------------------------------------------------
// iht_pkg
// Types and constants of the id/handle table.
// ----------------------------------------------------------------------------
package iht_pkg;

  localparam int unsigned TableEntries = 8;
  localparam int unsigned IdxW    = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned HandleW = 32;
  localparam int unsigned IdW     = 8;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TableEntries - 1);
  // ids run 1..255, the counter runs 0..254
  localparam logic [IdW:0]    IdCycle = (IdW+1)'(255);

  typedef enum logic [1:0] {
    ActAdd    = 2'd0,
    ActRemove = 2'd1,
    ActGet    = 2'd2,
    ActUnlock = 2'd3
  } iht_action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StNotFound = 2'd2,
    StBusy     = 2'd3
  } iht_status_e;

  typedef enum logic {
    SmIdle = 1'b0,
    SmScan = 1'b1
  } iht_state_e;

  typedef struct packed {
    iht_action_e        action;
    logic [HandleW-1:0] object_handle;
    logic [IdW-1:0]     lookup_id;
  } iht_req_t;

  typedef struct packed {
    iht_status_e        status;
    logic [IdW-1:0]     given_id;
    logic [HandleW-1:0] found_handle;
  } iht_res_t;

  typedef struct packed {
    logic [IdW-1:0]     id;
    logic [HandleW-1:0] handle;
  } iht_entry_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    iht_entry_t      data;
  } iht_wr_t;

endpackage

@@ hw/rtl/id_handle_table.sv @@
// ----------------------------------------------------------------------------
// id_handle_table
// Table of small rolling ids mapped to 32-bit object handles.
// ----------------------------------------------------------------------------
// Usage: drive req_i and raise start_i; the word is taken at the clock edge
// where start_i is high and busy_o is low. Actions: add (takes the first free
// entry and returns a fresh id 1..255), remove (frees the entry of a handle),
// get (looks up an id, returns its handle, locks the entry) and unlock.
// The result word is on res_o for exactly one cycle with res_valid_o high;
// the receiver cannot stall it and must take it in that cycle.
// The sequencer reads one entry per cycle from the entry memory and
// checks it in a single shared comparator, stopping at the first match or
// at the last entry, and the result follows in the next cycle. busy_o is
// high during the scan and low while the result is shown, so a new word can
// be taken in that cycle.
// Reset clears all used and lock flags and the id counter at once; id and
// handle storage is not cleared, since only used entries are ever compared.
// ----------------------------------------------------------------------------
`include "id_handle_table_macros.svh"

module id_handle_table import iht_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  iht_req_t req_i,
  output logic     busy_o,
  output logic     res_valid_o,
  output iht_res_t res_o
);

  logic [IdxW-1:0] rd_addr;
  iht_entry_t      rd_data;
  iht_wr_t         wr;

  iht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_o        (wr)
  );

  iht_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  `IHT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `IHT_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, res_valid_o, !res_valid_o)
  `IHT_ASSERT_IMPLIES(a_id_only_ok, clk_i, rst_ni, res_valid_o && res_o.given_id != '0, res_o.status == StOk && res_o.found_handle == '0)
  `IHT_ASSERT_IMPLIES(a_handle_only_ok, clk_i, rst_ni, res_valid_o && res_o.found_handle != '0, res_o.status == StOk && res_o.given_id == '0)

endmodule

@@ hw/rtl/iht_store.sv @@
// ----------------------------------------------------------------------------
// iht_store
// Entry memory: id and handle per entry, one write port, registered read.
// ----------------------------------------------------------------------------
module iht_store import iht_pkg::*; (
  input  logic            clk_i,
  input  iht_wr_t         wr_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output iht_entry_t      rd_data_o
);

  iht_entry_t mem_q [TableEntries];
  iht_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

@@ hw/rtl/iht_ctrl.sv @@
// ----------------------------------------------------------------------------
// iht_ctrl
// Scan sequencer: walks the entries one per cycle through a shared key
// comparator, then updates the flags, the id counter and the result.
// ----------------------------------------------------------------------------
module iht_ctrl import iht_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  iht_req_t        req_i,
  output logic            busy_o,
  output logic            res_valid_o,
  output iht_res_t        res_o,
  output logic [IdxW-1:0] rd_addr_o,
  input  iht_entry_t      rd_data_i,
  output iht_wr_t         wr_o
);

  iht_state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  iht_req_t req_q, req_d;
  logic [TableEntries-1:0] used_q, used_d;
  logic [TableEntries-1:0] locked_q, locked_d;
  logic [IdW-1:0] cnt_q, cnt_d;
  iht_res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  logic [HandleW-1:0] cmp_a, cmp_b;
  logic key_eq, handle_nz, cur_used, cur_locked, hit, finish;
  logic [IdW:0] cnt_inc;

  // shared key comparator: id for get, handle otherwise
  always_comb begin
    if (req_q.action == ActGet) begin
      cmp_a = HandleW'(req_q.lookup_id);
      cmp_b = HandleW'(rd_data_i.id);
    end else begin
      cmp_a = req_q.object_handle;
      cmp_b = rd_data_i.handle;
    end
    key_eq = (cmp_a == cmp_b);
  end

  assign handle_nz  = (req_q.object_handle != '0);
  assign cur_used   = used_q[idx_q];
  assign cur_locked = locked_q[idx_q];
  assign cnt_inc    = {1'b0, cnt_q} + (IdW+1)'(1);

  always_comb begin
    if (req_q.action == ActAdd) begin
      hit = !cur_used && handle_nz;
    end else begin
      hit = cur_used && key_eq && (req_q.action == ActGet || handle_nz);
    end
    finish = (state_q == SmScan) && (hit || idx_q == LastIdx);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SmIdle: if (start_i) state_d = SmScan;
      SmScan: if (finish) state_d = SmIdle;
      default: state_d = SmIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_d       = idx_q;
    req_d       = req_q;
    used_d      = used_q;
    locked_d    = locked_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    wr_o        = '0;
    wr_o.addr   = idx_q;
    wr_o.data.id     = IdW'(cnt_inc);
    wr_o.data.handle = req_q.object_handle;

    unique case (state_q)
      SmIdle: begin
        idx_d = '0;
        if (start_i) req_d = req_i;
      end
      SmScan: begin
        idx_d = idx_q + IdxW'(1);
        if (finish) begin
          idx_d       = '0;
          res_valid_d = 1'b1;
          res_d       = '0;
          if (hit) begin
            res_d.status = StOk;
            unique case (req_q.action)
              ActAdd: begin
                res_d.given_id  = IdW'(cnt_inc);
                used_d[idx_q]   = 1'b1;
                locked_d[idx_q] = 1'b0;
                wr_o.en         = 1'b1;
                // wrap modulo 255
                cnt_d = (cnt_inc >= IdCycle) ? IdW'(cnt_inc - IdCycle) : IdW'(cnt_inc);
              end
              ActRemove: begin
                if (cur_locked) begin
                  res_d.status = StBusy;
                end else begin
                  used_d[idx_q] = 1'b0;
                end
              end
              ActGet: begin
                locked_d[idx_q]    = 1'b1;
                res_d.found_handle = rd_data_i.handle;
              end
              ActUnlock: locked_d[idx_q] = 1'b0;
              default: res_d.status = StNotFound;
            endcase
          end else if (req_q.action == ActAdd && handle_nz) begin
            res_d.status = StFull;
          end else begin
            res_d.status = StNotFound;
          end
        end
      end
      default: idx_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SmIdle;
      used_q      <= '0;
      locked_q    <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      locked_q    <= locked_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign rd_addr_o   = idx_d;
  assign busy_o      = (state_q != SmIdle);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ verif/id_table_checker.sv @@
// ----------------------------------------------------------------------------
// id_table_checker
// Watches the request and result channels of id_handle_table, keeps its own
// copy of the table, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module id_table_checker import iht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  iht_req_t    req_i,
  input  logic        res_valid_i,
  input  iht_res_t    res_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned words_o,
  output int unsigned full_seen_o,
  output int unsigned busy_seen_o,
  output int unsigned id_one_o
);

  logic               slot_used   [TableEntries];
  logic               slot_locked [TableEntries];
  logic [IdW-1:0]     slot_id     [TableEntries];
  logic [HandleW-1:0] slot_handle [TableEntries];
  logic [IdW-1:0]     id_count;

  iht_res_t result_due_q [$];

  // Lowest used slot holding handle h; handle 0 never matches.
  function automatic int find_handle(logic [HandleW-1:0] h);
    int k;
    k = -1;
    if (h != '0) begin
      for (int i = int'(TableEntries) - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_handle[i] == h) k = i;
      end
    end
    return k;
  endfunction

  // Apply one request word to the table copy and return the result it causes.
  function automatic iht_res_t table_apply(iht_req_t w);
    iht_res_t r;
    int       k;
    r = '{status: StOk, given_id: '0, found_handle: '0};
    k = -1;
    case (w.action)
      ActAdd: begin
        if (w.object_handle == '0) begin
          r.status = StNotFound;
        end else begin
          for (int i = int'(TableEntries) - 1; i >= 0; i--) begin
            if (!slot_used[i]) k = i;
          end
          if (k < 0) begin
            r.status = StFull;
          end else begin
            r.given_id     = id_count + 1'b1;
            slot_used[k]   = 1'b1;
            slot_id[k]     = r.given_id;
            slot_handle[k] = w.object_handle;
            slot_locked[k] = 1'b0;
            // ids cycle 1..255, so the counter wraps after 254
            id_count = IdW'(({1'b0, id_count} + 1'b1) % IdCycle);
          end
        end
      end
      ActRemove: begin
        k = find_handle(w.object_handle);
        if (k < 0) begin
          r.status = StNotFound;
        end else if (slot_locked[k]) begin
          r.status = StBusy;
        end else begin
          slot_used[k]   = 1'b0;
          slot_locked[k] = 1'b0;
        end
      end
      ActGet: begin
        for (int i = int'(TableEntries) - 1; i >= 0; i--) begin
          if (slot_used[i] && slot_id[i] == w.lookup_id) k = i;
        end
        if (k < 0) begin
          r.status = StNotFound;
        end else begin
          slot_locked[k] = 1'b1;
          r.found_handle = slot_handle[k];
        end
      end
      default: begin
        k = find_handle(w.object_handle);
        if (k < 0) r.status = StNotFound;
        else slot_locked[k] = 1'b0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    iht_res_t due;
    if (!rst_ni) begin
      for (int i = 0; i < int'(TableEntries); i++) begin
        slot_used[i]   = 1'b0;
        slot_locked[i] = 1'b0;
        slot_id[i]     = '0;
        slot_handle[i] = '0;
      end
      id_count = '0;
      result_due_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      words_o      = 0;
      full_seen_o  = 0;
      busy_seen_o  = 0;
      id_one_o     = 0;
    end else begin
      // results belong to earlier words, so compare before taking a new one
      if (res_valid_i) begin
        if (res_i.status == StFull) full_seen_o++;
        if (res_i.status == StBusy) busy_seen_o++;
        if (res_i.given_id == 8'd1) id_one_o++;
        if (result_due_q.size() == 0) begin
          $error("result word with no request waiting: status %0d id %0d handle %08h",
                 res_i.status, res_i.given_id, res_i.found_handle);
          fail_count_o++;
        end else begin
          due = result_due_q.pop_front();
          if (res_i.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, res_i.status);
            fail_count_o++;
          end
          if (res_i.given_id !== due.given_id) begin
            $error("given_id: expected %0d, got %0d", due.given_id, res_i.given_id);
            fail_count_o++;
          end
          if (res_i.found_handle !== due.found_handle) begin
            $error("found_handle: expected %08h, got %08h",
                   due.found_handle, res_i.found_handle);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        result_due_q.push_back(table_apply(req_i));
        words_o++;
      end
      pending_o = result_due_q.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for id_handle_table: directed corner words, then mixed random
// traffic over a small handle pool, a table drain, long add/lock/remove
// churn that wraps the id counter, and a last burst without sender gaps.
// ----------------------------------------------------------------------------
module tb;
  import iht_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PoolSize   = 10;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  iht_req_t req_i;
  logic     busy_o;
  logic     res_valid_o;
  iht_res_t res_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_sent;
  int unsigned full_seen;
  int unsigned busy_seen;
  int unsigned id_one;

  logic [HandleW-1:0] handle_pool [PoolSize];
  logic [IdW-1:0]     recent_ids  [8];
  int unsigned        recent_wr = 0;
  logic [IdW-1:0]     last_given = '0;
  iht_status_e        last_status = StOk;
  int unsigned        idle_pct = 0;

  id_handle_table u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .req_i,
    .busy_o,
    .res_valid_o,
    .res_o
  );

  id_table_checker u_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i       (busy_o),
    .req_i,
    .res_valid_i  (res_valid_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .words_o      (words_sent),
    .full_seen_o  (full_seen),
    .busy_seen_o  (busy_seen),
    .id_one_o     (id_one)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles", CycleLimit);
    $display("[id_handle_table] ERROR");
    $finish;
  end

  // Remember recent ids so that gets mostly hit live entries.
  always @(posedge clk_i) begin
    if (res_valid_o) begin
      last_status <= res_o.status;
      if (res_o.status == StOk && res_o.given_id != '0) begin
        last_given             <= res_o.given_id;
        recent_ids[recent_wr]  <= res_o.given_id;
        recent_wr              <= (recent_wr + 1) % 8;
      end
    end
  end

  task automatic send_word(iht_action_e act, logic [HandleW-1:0] h, logic [IdW-1:0] v);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= '{action: act, object_handle: h, lookup_id: v};
    // hold the word until the block takes it
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic random_word();
    iht_action_e        act;
    logic [HandleW-1:0] h;
    logic [IdW-1:0]     v;
    act = iht_action_e'($urandom_range(3));
    h   = handle_pool[$urandom_range(PoolSize - 1)];
    // adds stay in the pool so the table can be drained later
    if (act != ActAdd && $urandom_range(99) < 15) h = $urandom;
    if (act == ActAdd && $urandom_range(99) < 3) h = '0;
    v = ($urandom_range(99) < 80) ? recent_ids[$urandom_range(7)] : IdW'($urandom_range(255));
    send_word(act, h, v);
  endtask

  // Unlock and remove every copy of each pool handle until none is left.
  task automatic clear_table();
    for (int p = 0; p < int'(PoolSize); p++) begin
      do begin
        send_word(ActUnlock, handle_pool[p], IdW'($urandom_range(255)));
        send_word(ActRemove, handle_pool[p], IdW'($urandom_range(255)));
        wait_quiet();
      end while (last_status != StNotFound);
    end
  endtask

  // Add a fresh handle, sometimes lock it and fight the lock, then remove it.
  task automatic churn_cycle();
    logic [HandleW-1:0] h;
    do h = $urandom; while (h == '0);
    send_word(ActAdd, h, IdW'($urandom_range(255)));
    if ($urandom_range(2) == 0) begin
      wait_quiet();
      send_word(ActGet, HandleW'($urandom), last_given);
      send_word(ActRemove, h, IdW'($urandom_range(255)));
      send_word(ActUnlock, h, IdW'($urandom_range(255)));
    end
    send_word(ActRemove, h, IdW'($urandom_range(255)));
  endtask

  initial begin
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    handle_pool = '{32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hA5A5_A5A5,
                    32'h5A5A_5A5A, 32'h0000_0002, 32'h0000_0003, 32'h0000_0007,
                    32'h0000_0000, 32'h0000_0000};
    for (int p = 8; p < int'(PoolSize); p++) begin
      do handle_pool[p] = $urandom; while (handle_pool[p] == '0);
    end
    for (int i = 0; i < 8; i++) recent_ids[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 6;
    // empty table, reserved handle and id 0
    send_word(ActGet,    32'h0000_0000, 8'd0);
    send_word(ActRemove, 32'h0000_0000, 8'd255);
    send_word(ActUnlock, 32'h0000_0000, 8'd0);
    send_word(ActAdd,    32'h0000_0000, 8'd0);
    // fill all eight entries, handle 1 twice, then one more add that finds the table full
    send_word(ActAdd,    32'hFFFF_FFFF, 8'd0);
    send_word(ActAdd,    32'h0000_0001, 8'd255);
    send_word(ActAdd,    32'h8000_0000, 8'd0);
    send_word(ActAdd,    32'hA5A5_A5A5, 8'd0);
    send_word(ActAdd,    32'h0000_0001, 8'd0);
    send_word(ActAdd,    32'h5A5A_5A5A, 8'd0);
    send_word(ActAdd,    32'h0000_0002, 8'd0);
    send_word(ActAdd,    32'h0000_0003, 8'd0);
    send_word(ActAdd,    32'h0000_0004, 8'd0);
    // lock the second copy of handle 1, then work through it
    send_word(ActGet,    32'hFFFF_FFFF, 8'd5);
    send_word(ActRemove, 32'h0000_0001, 8'd0);
    send_word(ActRemove, 32'h0000_0001, 8'd0);
    send_word(ActUnlock, 32'h0000_0001, 8'd0);
    send_word(ActUnlock, 32'h0000_0001, 8'd0);
    send_word(ActRemove, 32'h0000_0001, 8'd0);
    send_word(ActRemove, 32'h0000_0001, 8'd0);
    send_word(ActGet,    32'h0000_0000, 8'd255);
    send_word(ActGet,    32'h0000_0000, 8'd8);
    send_word(ActUnlock, 32'h0000_0007, 8'd0);
    send_word(ActAdd,    32'h0000_0007, 8'd0);
    send_word(ActGet,    32'h0000_0000, 8'd9);

    repeat (150) random_word();
    clear_table();

    idle_pct = 52;
    repeat (260) churn_cycle();
    wait_quiet();

    idle_pct = 0;
    repeat (100) random_word();

    wait_quiet();
    repeat (20) @(negedge clk_i);

    $display("sent %0d words with the table filled, drained and churned", words_sent);
    $display("seen %0d full and %0d busy replies; id 1 handed out %0d times",
             full_seen, busy_seen, id_one);
    if (fail_count == 0) begin
      $display("[id_handle_table] OK");
    end else begin
      $display("[id_handle_table] ERROR");
    end
    $finish;
  end

endmodule

@@ id_handle_table.f @@
+incdir+hw/rtl
hw/rtl/iht_pkg.sv
hw/rtl/iht_store.sv
hw/rtl/iht_ctrl.sv
hw/rtl/id_handle_table.sv
verif/id_table_checker.sv
verif/tb.sv
